### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the monitor top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define SAM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication: the consequent is checked in the cycle after the antecedent.
`define SAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sam_pkg.sv
// ----------------------------------------------------------------------------
// sam_pkg
// Types and constants of the speed agreement monitor.
// ----------------------------------------------------------------------------
package sam_pkg;

	// register reset values
	localparam logic [7:0] MIN_GPS_RESET = 8'd40;
	localparam logic [6:0] DEV_PCT_RESET = 7'd11;
	localparam logic [9:0] RUN_LEN_RESET = 10'd300;
	localparam logic [7:0] PCT_SCALE     = 8'd100;

	// register index codes (paddr[3:2])
	localparam logic [1:0] REG_MIN_GPS = 2'd0;
	localparam logic [1:0] REG_DEV_PCT = 2'd1;
	localparam logic [1:0] REG_RUN_LEN = 2'd2;

	localparam int CNT_W = 10;

	typedef enum logic [1:0] {
		ALU_ABSDIFF,
		ALU_MUL,
		ALU_SUB,
		ALU_GE
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_LHS,
		S_RHS,
		S_CMP,
		S_START,
		S_RD,
		S_LOAD
	} state_t;

endpackage

### rtl/sam_alu.sv
// ----------------------------------------------------------------------------
// sam_alu
// Shared arithmetic unit: absolute difference, 8x8 multiply, subtract, compare.
// ----------------------------------------------------------------------------
module sam_alu (
	input  sam_pkg::alu_req_t req,
	output logic [31:0]       result
);
	import sam_pkg::*;

	logic        ge;
	logic [15:0] prod;

	assign ge   = (req.a >= req.b);
	assign prod = req.a[7:0] * req.b[7:0];

	always_comb begin
		unique case (req.op)
			ALU_ABSDIFF: result = ge ? (req.a - req.b) : (req.b - req.a);
			ALU_MUL:     result = {16'd0, prod};
			ALU_SUB:     result = req.a - req.b;
			ALU_GE:      result = {31'd0, ge};
			default:     result = '0;
		endcase
	end

endmodule

### rtl/sam_pair_mem.sv
// ----------------------------------------------------------------------------
// sam_pair_mem
// Speed pair store, one write and one registered read port.
// ----------------------------------------------------------------------------
module sam_pair_mem #(
	parameter int DEPTH = 60,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [15:0]      wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [15:0]      rd_data
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/speed_agreement_monitor_top.sv
// ----------------------------------------------------------------------------
// speed_agreement_monitor_top
// Compares wheel-pulse and GPS speed once per sample and reports long runs.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): one transfer per per-second sample. s_tready is high
//    only while the sequencer is idle; one sample at a time is processed.
//  - An ignored sample returns straight to idle, a non-qualifying one after the
//    difference step; the agreement check goes through one shared ALU (abs
//    difference, two 8x8 products, compare), one step per cycle.
//  - When a run completes, S_START forms the start time, then the STORED_PAIRS
//    results stream out, each through a store read (S_RD) and an output
//    register load (S_LOAD).
//  - Output stream (m_*): m_tlast marks the final pair of a record. A stalled
//    receiver holds the output register and the sequencer waits; the next
//    sample is accepted while the final pair still waits.
//  - APB port: three registers at 0x0, 0x4, 0x8, writable only while idle; this
//    binds the user, the block itself does not enforce it. Reset (arst_n low)
//    restores register defaults, clears both run counters and the fault flag,
//    and enables recording. The pair store is not cleared.
module speed_agreement_monitor_top #(
	parameter int STORED_PAIRS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] pulse_second_speed, [15:8] pulse_instant_speed, [23:16] gps_speed,
	// [24] nav_fix, [25] midnight, [57:26] time_now, [63:58] zero
	input  logic [63:0] s_tdata,
	// record stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] record_status, [32:1] start_time, [64:33] end_time, [70:65] pair_index,
	// [78:71] pair_pulse_speed, [86:79] pair_gps_speed, [87] fault_flag
	output logic [87:0] m_tdata,
	output logic        m_tlast
);
	import sam_pkg::*;

	localparam int IDX_W = (STORED_PAIRS > 1) ? $clog2(STORED_PAIRS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORED_PAIRS - 1);
	localparam logic [CNT_W-1:0] PAIRS_CNT = CNT_W'(STORED_PAIRS);

	// configuration registers
	logic [7:0]       min_gps_q;
	logic [6:0]       dev_pct_q;
	logic [CNT_W-1:0] run_len_q;

	// run state
	logic [CNT_W-1:0] abn_run_q, nor_run_q;
	logic             enabled_q, status_q, rec_abn_q;

	// latched sample
	logic [7:0]  ps_q, pi_q, gs_q;
	logic        fix_q;
	logic [31:0] now_q;

	// arithmetic scratch
	logic [31:0] acc_q;
	logic [15:0] lhs_q;
	logic [31:0] start_q;
	logic [IDX_W-1:0] idx_q;

	// output register
	logic        m_valid_q, m_last_q;
	logic [87:0] m_data_q;

	state_t state_q, state_d;

	alu_req_t    alu_req;
	logic [31:0] alu_res;

	logic             cfg_wr, s_xfer, out_free, qualifies, abnormal;
	logic [CNT_W-1:0] cnt_new, cnt_m1;
	logic             store_en, emit;
	logic [15:0]      rd_pair;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == S_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	// APB read mux
	always_comb begin
		unique case (paddr[3:2])
			REG_MIN_GPS: prdata = {24'd0, min_gps_q};
			REG_DEV_PCT: prdata = {25'd0, dev_pct_q};
			REG_RUN_LEN: prdata = {22'd0, run_len_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gps_q <= MIN_GPS_RESET;
			dev_pct_q <= DEV_PCT_RESET;
			run_len_q <= RUN_LEN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MIN_GPS: min_gps_q <= pwdata[7:0];
				REG_DEV_PCT: dev_pct_q <= pwdata[6:0];
				REG_RUN_LEN: run_len_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// qualification and counter step, evaluated in S_DIFF / S_CMP
	assign qualifies = (gs_q > min_gps_q) && (ps_q != 8'd0) && (pi_q != 8'd0) && fix_q;
	assign abnormal  = alu_res[0];
	assign cnt_new   = (abnormal ? abn_run_q : nor_run_q) + CNT_W'(1);
	assign cnt_m1    = cnt_new - CNT_W'(1);
	assign store_en  = (state_q == S_CMP) && (cnt_new <= PAIRS_CNT);
	assign emit      = (state_q == S_CMP) && (cnt_new > PAIRS_CNT) && (cnt_new >= run_len_q);

	sam_alu u_alu (
		.req    (alu_req),
		.result (alu_res)
	);

	sam_pair_mem #(
		.DEPTH (STORED_PAIRS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (store_en),
		.wr_addr (cnt_m1[IDX_W-1:0]),
		.wr_data ({gs_q, ps_q}),
		.rd_addr (idx_q),
		.rd_data (rd_pair)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ALU operand selection
	always_comb begin
		state_d     = state_q;
		alu_req.op  = ALU_ABSDIFF;
		alu_req.a   = {24'd0, ps_q};
		alu_req.b   = {24'd0, gs_q};
		unique case (state_q)
			S_IDLE: begin
				if (s_xfer && (s_tdata[25] || enabled_q)) state_d = S_DIFF;
			end
			S_DIFF: begin
				state_d = qualifies ? S_LHS : S_IDLE;
			end
			S_LHS: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = acc_q;
				alu_req.b  = {24'd0, PCT_SCALE};
				state_d    = S_RHS;
			end
			S_RHS: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = {25'd0, dev_pct_q};
				alu_req.b  = {24'd0, gs_q};
				state_d    = S_CMP;
			end
			S_CMP: begin
				alu_req.op = ALU_GE;
				alu_req.a  = {16'd0, lhs_q};
				alu_req.b  = acc_q;
				state_d    = emit ? S_START : S_IDLE;
			end
			S_START: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = now_q;
				alu_req.b  = {22'd0, run_len_q};
				state_d    = S_RD;
			end
			S_RD: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (out_free) state_d = (idx_q == LAST_IDX) ? S_IDLE : S_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// run control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abn_run_q <= '0;
			nor_run_q <= '0;
			enabled_q <= 1'b1;
			status_q  <= 1'b0;
		end else begin
			if (s_xfer && s_tdata[25]) enabled_q <= 1'b1;
			if (state_q == S_DIFF && !qualifies) begin
				abn_run_q <= '0;
				nor_run_q <= '0;
			end
			if (state_q == S_CMP) begin
				if (abnormal) begin
					nor_run_q <= '0;
					abn_run_q <= emit ? '0 : cnt_new;
				end else begin
					abn_run_q <= '0;
					nor_run_q <= emit ? '0 : cnt_new;
				end
				if (emit) begin
					enabled_q <= 1'b0;
					status_q  <= abnormal;
				end
			end
		end
	end

	// sample latch and arithmetic scratch
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			ps_q  <= s_tdata[7:0];
			pi_q  <= s_tdata[15:8];
			gs_q  <= s_tdata[23:16];
			fix_q <= s_tdata[24];
			now_q <= s_tdata[57:26];
		end
		case (state_q)
			S_DIFF:  acc_q   <= alu_res;
			S_LHS:   lhs_q   <= alu_res[15:0];
			S_RHS:   acc_q   <= alu_res;
			S_START: start_q <= alu_res;
			default: ;
		endcase
		if (emit) rec_abn_q <= abnormal;
	end

	// pair index walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == S_START) begin
			idx_q <= '0;
		end else if (state_q == S_LOAD && out_free && idx_q != LAST_IDX) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
		end else if (state_q == S_LOAD && out_free) begin
			m_valid_q <= 1'b1;
			m_last_q  <= (idx_q == LAST_IDX);
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && out_free) begin
			m_data_q <= {status_q, rd_pair[15:8], rd_pair[7:0], 6'(idx_q),
				now_q, start_q, rec_abn_q};
		end
	end

	`include "assert_macros.svh"

	`SAM_ASSERT(a_one_run_active, clk, arst_n, !(abn_run_q != '0 && nor_run_q != '0), "both run counters nonzero")
	`SAM_ASSERT(a_last_index, clk, arst_n, !(m_tvalid && m_tlast) || (m_tdata[70:65] == 6'(LAST_IDX)), "tlast on wrong pair index")
	`SAM_ASSERT_NEXT(a_emit_disables, clk, arst_n, emit, (state_q == S_START) && !enabled_q, "record start without disable")

endmodule

### dv/sam_tb_pkg.sv
// ----------------------------------------------------------------------------
// sam_tb_pkg
// Sample and record-pair types plus the scoreboard that predicts the records
// of the speed agreement monitor and checks every pair that leaves the block.
// ----------------------------------------------------------------------------
package sam_tb_pkg;
	import sam_pkg::*;

	localparam int PAIR_SLOTS = 60;

	typedef enum logic [1:0] {
		CLS_JUNK,
		CLS_NORMAL,
		CLS_ABNORMAL
	} sample_class_t;

	typedef struct packed {
		logic [7:0]  pulse_second_speed;
		logic [7:0]  pulse_instant_speed;
		logic [7:0]  gps_speed;
		logic        nav_fix;
		logic        midnight;
		logic [31:0] time_now;
	} sample_t;

	typedef struct packed {
		logic        record_status;
		logic [31:0] start_time;
		logic [31:0] end_time;
		logic [5:0]  pair_index;
		logic [7:0]  pair_pulse_speed;
		logic [7:0]  pair_gps_speed;
		logic        fault_flag;
		logic        last;
	} pair_t;

	class agreement_scoreboard;
		logic [7:0] min_gps;
		logic [6:0] dev_pct;
		logic [9:0] run_len;
		logic [9:0] abnormal_count;
		logic [9:0] normal_count;
		logic       recording;
		logic       fault;
		logic [7:0] kept_pulse [PAIR_SLOTS];
		logic [7:0] kept_gps [PAIR_SLOTS];
		pair_t      due_pairs [$];
		int         mismatches;
		int         samples_taken;
		int         records_emitted;

		function new();
			min_gps         = MIN_GPS_RESET;
			dev_pct         = DEV_PCT_RESET;
			run_len         = RUN_LEN_RESET;
			abnormal_count  = '0;
			normal_count    = '0;
			recording       = 1'b1;
			fault           = 1'b0;
			mismatches      = 0;
			samples_taken   = 0;
			records_emitted = 0;
		endfunction

		function void set_register(input logic [1:0] idx, input logic [31:0] val);
			case (idx)
				REG_MIN_GPS: min_gps = val[7:0];
				REG_DEV_PCT: dev_pct = val[6:0];
				REG_RUN_LEN: run_len = val[9:0];
				default: ;
			endcase
		endfunction

		function sample_class_t classify(input sample_t s);
			int diff;
			if (!(s.gps_speed > min_gps && s.pulse_second_speed != 8'd0 &&
					s.pulse_instant_speed != 8'd0 && s.nav_fix)) begin
				return CLS_JUNK;
			end
			if (s.pulse_second_speed >= s.gps_speed) begin
				diff = int'(s.pulse_second_speed) - int'(s.gps_speed);
			end else begin
				diff = int'(s.gps_speed) - int'(s.pulse_second_speed);
			end
			if (int'(PCT_SCALE) * diff >= int'(dev_pct) * int'(s.gps_speed)) begin
				return CLS_ABNORMAL;
			end
			return CLS_NORMAL;
		endfunction

		// one accepted sample: update runs, queue a full record when a run completes
		function void note_sample(input sample_t s);
			sample_class_t kind;
			logic [9:0]    run;
			pair_t         p;
			int            k;
			if (s.midnight) begin
				recording = 1'b1;
			end
			if (!recording) begin
				return;
			end
			samples_taken++;
			kind = classify(s);
			if (kind == CLS_JUNK) begin
				abnormal_count = '0;
				normal_count   = '0;
				return;
			end
			if (kind == CLS_ABNORMAL) begin
				normal_count   = '0;
				abnormal_count = abnormal_count + 10'd1;
				run            = abnormal_count;
			end else begin
				abnormal_count = '0;
				normal_count   = normal_count + 10'd1;
				run            = normal_count;
			end
			if (run <= PAIR_SLOTS) begin
				kept_pulse[run - 10'd1] = s.pulse_second_speed;
				kept_gps[run - 10'd1]   = s.gps_speed;
			end else if (run >= run_len) begin
				abnormal_count = '0;
				normal_count   = '0;
				fault          = (kind == CLS_ABNORMAL);
				recording      = 1'b0;
				records_emitted++;
				for (k = 0; k < PAIR_SLOTS; k++) begin
					p.record_status    = fault;
					p.start_time       = s.time_now - 32'(run_len);
					p.end_time         = s.time_now;
					p.pair_index       = 6'(k);
					p.pair_pulse_speed = kept_pulse[k];
					p.pair_gps_speed   = kept_gps[k];
					p.fault_flag       = fault;
					p.last             = (k == PAIR_SLOTS - 1);
					due_pairs.push_back(p);
				end
			end
		endfunction

		function string show(input pair_t p);
			return $sformatf("status=%0d start=%h end=%h idx=%0d pulse=%0d gps=%0d fault=%0d last=%0d",
				p.record_status, p.start_time, p.end_time, p.pair_index,
				p.pair_pulse_speed, p.pair_gps_speed, p.fault_flag, p.last);
		endfunction

		function void check_pair(input pair_t got);
			pair_t want;
			if (due_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected record pair: %s", show(got));
				end
				return;
			end
			want = due_pairs.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("pair mismatch, expected %s", show(want));
					$display("                 actual %s", show(got));
				end
			end
		endfunction
	endclass

endpackage

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives per-second speed samples into the speed agreement monitor, predicts
// the 60-pair records it must emit and checks each pair as it leaves. Config
// is changed between phases through the APB port.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sam_pkg::*;
	import sam_tb_pkg::*;

	localparam int SETTLE_CYCLES = 8;                    // longest per-sample work
	localparam int DRAIN_CYCLES  = 2 * PAIR_SLOTS + 8;   // one record worth
	localparam int HOLD_CYCLES   = 400;                  // long receiver hold-off

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	// [7:0] pulse_second_speed, [15:8] pulse_instant_speed, [23:16] gps_speed,
	// [24] nav_fix, [25] midnight, [57:26] time_now, [63:58] zero
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// [0] record_status, [32:1] start_time, [64:33] end_time, [70:65] pair_index,
	// [78:71] pair_pulse_speed, [86:79] pair_gps_speed, [87] fault_flag
	logic [87:0] m_tdata;
	logic        m_tlast;

	agreement_scoreboard sb;
	bit   calm = 1'b0;   // no idling on either side once set
	logic hold_off;      // long receiver stall requested by the pressure process

	speed_agreement_monitor_top #(
		.STORED_PAIRS(PAIR_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic sample_t sample_of(input logic [7:0] ps, pi, gs,
			input logic fix, mid, input logic [31:0] t);
		sample_t s;
		s.pulse_second_speed  = ps;
		s.pulse_instant_speed = pi;
		s.gps_speed           = gs;
		s.nav_fix             = fix;
		s.midnight            = mid;
		s.time_now            = t;
		return s;
	endfunction

	// Random sample of the wanted class under the current config. Qualifying
	// classes are found by retrying; if the config makes the class impossible
	// (e.g. zero deviation has no normal samples) the last try is kept.
	function automatic sample_t make_sample(input sample_class_t want);
		sample_t s;
		int      spread;
		int      v;
		int      tries;
		s.time_now            = $urandom();
		s.midnight            = 1'b0;
		s.nav_fix             = 1'b1;
		s.pulse_instant_speed = 8'($urandom_range(1, 255));
		if (want == CLS_JUNK || sb.min_gps == 8'd255) begin
			s.pulse_second_speed  = 8'($urandom());
			s.pulse_instant_speed = 8'($urandom());
			s.gps_speed           = 8'($urandom());
			s.nav_fix             = 1'($urandom());
			// knock out one qualifying condition
			case ($urandom_range(0, 3))
				0: s.gps_speed = 8'($urandom_range(0, int'(sb.min_gps)));
				1: s.pulse_second_speed = 8'd0;
				2: s.pulse_instant_speed = 8'd0;
				default: s.nav_fix = 1'b0;
			endcase
			return s;
		end
		for (tries = 0; tries < 200; tries++) begin
			s.gps_speed = 8'($urandom_range(int'(sb.min_gps) + 1, 255));
			if (want == CLS_NORMAL) begin
				// stay within half the allowed deviation
				spread = int'(s.gps_speed) * int'(sb.dev_pct) / 200;
				v = int'(s.gps_speed) - spread + int'($urandom_range(0, 2 * spread));
				if (v < 1) v = 1;
				if (v > 255) v = 255;
				s.pulse_second_speed = 8'(v);
			end else begin
				s.pulse_second_speed = 8'($urandom_range(1, 255));
			end
			if (sb.classify(s) == want) break;
		end
		return s;
	endfunction

	// One sample transfer; an optional idle gap goes before it.
	task automatic send_sample(input sample_t s);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, s.time_now, s.midnight, s.nav_fix, s.gps_speed,
			s.pulse_instant_speed, s.pulse_second_speed};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(s);
	endtask

	// A run of same-class samples. first_mid puts a midnight marker on the
	// first one; mid_odds > 0 scatters further markers at 1 in mid_odds;
	// seq_time stamps the samples 0, 1, 2, ... instead of random times.
	task automatic send_run(input sample_class_t kind, input int len, input bit first_mid,
			input int mid_odds, input bit seq_time);
		sample_t s;
		int      i;
		for (i = 0; i < len; i++) begin
			s = make_sample(kind);
			if (i == 0) begin
				s.midnight = first_mid;
			end else if (mid_odds > 0) begin
				s.midnight = ($urandom_range(1, mid_odds) == 1);
			end
			if (seq_time) s.time_now = 32'(i);
			send_sample(s);
		end
	endtask

	// Stop offering samples and wait until every predicted pair is out and
	// any trailing non-record sample has finished.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.due_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup, access, then back to idle.
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_setup();
		settle();
		apb_write(REG_MIN_GPS, 32'($urandom_range(0, 80)));
		apb_write(REG_DEV_PCT, 32'($urandom_range(5, 40)));
		apb_write(REG_RUN_LEN, 32'($urandom_range(61, 80)));
	endtask

	// Runs of random content mixed with short bursts of junk samples. Runs
	// long enough to complete a record are only sent while records are wanted.
	task automatic random_traffic(input int want_samples, input int want_records);
		int            base_samples;
		int            base_records;
		int            len;
		sample_class_t kind;
		base_samples = sb.samples_taken;
		base_records = sb.records_emitted;
		while (sb.samples_taken - base_samples < want_samples ||
				sb.records_emitted - base_records < want_records) begin
			if ($urandom_range(0, 9) < 3) begin
				kind = CLS_JUNK;
				len  = $urandom_range(1, 3);
			end else begin
				kind = $urandom_range(0, 1) ? CLS_NORMAL : CLS_ABNORMAL;
				if (sb.records_emitted - base_records < want_records &&
						$urandom_range(0, 1)) begin
					len = int'(sb.run_len) + int'($urandom_range(0, 4));
				end else begin
					len = $urandom_range(1, 8);
				end
			end
			send_run(kind, len, $urandom_range(0, 2) == 0, 24, 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Record receiver: checks every pair transfer, stalls in random bursts
	// and for the long hold-off.
	// ------------------------------------------------------------------------
	initial begin
		int    stall_left;
		pair_t got;
		stall_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.record_status    = m_tdata[0];
				got.start_time       = m_tdata[32:1];
				got.end_time         = m_tdata[64:33];
				got.pair_index       = m_tdata[70:65];
				got.pair_pulse_speed = m_tdata[78:71];
				got.pair_gps_speed   = m_tdata[86:79];
				got.fault_flag       = m_tdata[87];
				got.last             = m_tlast;
				sb.check_pair(got);
			end
			if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 18);
			end
			if (hold_off || stall_left > 0) begin
				m_tready <= 1'b0;
				if (stall_left > 0) stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Pressure: once the first record starts, hold the receiver off long
	// enough that the record backs up and the sample input stalls.
	initial begin
		hold_off <= 1'b0;
		@(posedge arst_n);
		do @(posedge clk); while (!m_tvalid);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples at reset config (min 40, deviation 11%, run 300).
		send_sample(sample_of(8'd100, 8'd100, 8'd100, 1'b1, 1'b1, 32'd0)); // marker while enabled
		send_sample(sample_of(8'd40, 8'd40, 8'd40, 1'b1, 1'b0, 32'd1));    // gps at minimum
		send_sample(sample_of(8'd41, 8'd1, 8'd41, 1'b1, 1'b0, $urandom()));
		send_sample(sample_of(8'd0, 8'd50, 8'd50, 1'b1, 1'b0, $urandom())); // no pulse speed
		send_sample(sample_of(8'd50, 8'd0, 8'd50, 1'b1, 1'b0, $urandom())); // no instant speed
		send_sample(sample_of(8'd50, 8'd50, 8'd50, 1'b0, 1'b0, $urandom())); // no fix
		send_sample(sample_of(8'd111, 8'd60, 8'd100, 1'b1, 1'b0, $urandom())); // exactly 11%
		send_sample(sample_of(8'd89, 8'd60, 8'd100, 1'b1, 1'b0, $urandom()));  // 11% below
		send_sample(sample_of(8'd90, 8'd60, 8'd100, 1'b1, 1'b0, $urandom()));  // just inside
		send_sample(sample_of(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 32'hFFFF_FFFF));
		send_sample(sample_of(8'd1, 8'd255, 8'd255, 1'b1, 1'b0, 32'h8000_0000));
		send_sample(sample_of(8'd255, 8'd255, 8'd0, 1'b1, 1'b0, $urandom())); // gps zero
		send_sample(sample_of(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0));

		// Low extremes: every qualifying sample is abnormal, shortest run.
		// Times count from zero so the start time wraps below zero.
		settle();
		apb_write(REG_MIN_GPS, 32'd0);
		apb_write(REG_DEV_PCT, 32'd0);
		apb_write(REG_RUN_LEN, 32'd61);
		send_run(CLS_ABNORMAL, 61, 1'b0, 0, 1'b1);
		// Recording is now off: these are ignored until a midnight marker.
		send_run(CLS_ABNORMAL, 2, 1'b0, 0, 1'b0);
		send_run(CLS_JUNK, 1, 1'b1, 0, 1'b0);

		// High extremes: nothing passes the gps minimum.
		settle();
		apb_write(REG_MIN_GPS, 32'd255);
		apb_write(REG_DEV_PCT, 32'd100);
		apb_write(REG_RUN_LEN, 32'd1023);
		send_run(CLS_NORMAL, 3, 1'b0, 0, 1'b0);

		// Deviation above 100% and a run length below the stored-pair count:
		// the record comes out once the count passes the store size.
		settle();
		apb_write(REG_MIN_GPS, 32'd20);
		apb_write(REG_DEV_PCT, 32'd127);
		apb_write(REG_RUN_LEN, 32'd0);
		send_run(CLS_NORMAL, 61, 1'b0, 0, 1'b0);
		send_run(CLS_JUNK, 1, 1'b1, 0, 1'b0);

		// Short random runs under a random config.
		random_setup();
		random_traffic(10, 0);

		// Final stretch without idling on either side.
		calm = 1'b1;
		random_traffic(10, 0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.due_pairs.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/sam_pkg.sv
rtl/sam_alu.sv
rtl/sam_pair_mem.sv
rtl/speed_agreement_monitor_top.sv
dv/sam_tb_pkg.sv
dv/testbench.sv
